// File: hdl/adaptive_search_stop_unit_assert.svh
// Assertion macros shared by the RTL modules of the stopping unit.
// Each module that uses them has a clock clk_i and an active-low reset rst_ni.
`ifndef ADAPTIVE_SEARCH_STOP_UNIT_ASSERT_SVH
`define ADAPTIVE_SEARCH_STOP_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ADSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/adss_pkg.sv
`default_nettype none

package adss_pkg;

  localparam int unsigned STEPS_W   = 32;
  localparam int unsigned MEAN_W    = 48;
  localparam int unsigned SOS_W     = 64;
  localparam int unsigned VAR_W     = 63;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned ACC_W     = 128;
  localparam int unsigned MPL_W     = 64;
  localparam int unsigned DVS_W     = 32;
  localparam int unsigned CNT_W     = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 8'd1;

  localparam logic [CFG_W-1:0] ALPHA_RESET = 16'd256;
  localparam logic [CFG_W-1:0] BETA_RESET  = 16'd0;
  localparam logic [CFG_W-1:0] ALPHA_HALF  = 16'd128;

  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_LATCH = 4'd1,
    OP_FIRST = 4'd2,
    OP_DIV1  = 4'd3,
    OP_MEAN  = 4'd4,
    OP_MUL1  = 4'd5,
    OP_SACC  = 4'd6,
    OP_DIV2  = 4'd7,
    OP_VAR   = 4'd8,
    OP_EVAL  = 4'd9,
    OP_STEP  = 4'd10,
    OP_AMUL  = 4'd11,
    OP_CMP   = 4'd12,
    OP_OUT   = 4'd13
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   func;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic quick;
    logic busy;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hdl/adss_if.sv
`default_nettype none

interface adss_in_if #(
  parameter int unsigned GAIN_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [GAIN_WIDTH-1:0] gain;

  modport source (output valid, output func, output gain, input ready);
  modport sink (input valid, input func, input gain, output ready);
endinterface

interface adss_out_if;
  logic                               valid;
  logic                               ready;
  logic                               stop;
  logic [adss_pkg::STEPS_W-1:0]       steps;
  logic signed [adss_pkg::MEAN_W-1:0] mean_q16;
  logic [adss_pkg::VAR_W-1:0]         variance_q16;

  modport source (output valid, output stop, output steps, output mean_q16,
                  output variance_q16, input ready);
  modport sink (input valid, input stop, input steps, input mean_q16,
                input variance_q16, output ready);
endinterface

`default_nettype wire

// File: hdl/adss_muldiv.sv
`default_nettype none

module adss_muldiv (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic                         div_i,
  input  wire logic [adss_pkg::ACC_W-1:0]   mcand_i,
  input  wire logic [adss_pkg::MPL_W-1:0]   mpl_i,
  input  wire logic [adss_pkg::DVS_W-1:0]   divisor_i,
  output logic                              busy_o,
  output logic [adss_pkg::ACC_W-1:0]        prod_o,
  output logic [adss_pkg::MPL_W-1:0]        quot_o
);

  localparam int unsigned AW = adss_pkg::ACC_W;
  localparam int unsigned MW = adss_pkg::MPL_W;
  localparam int unsigned DW = adss_pkg::DVS_W;
  localparam int unsigned CW = adss_pkg::CNT_W;
  localparam logic [CW-1:0] DIV_STEPS = CW'(MW);

  logic          div_q, div_d;
  logic [MW-1:0] shr_q, shr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] acc_q, acc_d;
  logic [AW-1:0] mcand_q, mcand_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          ge;

  assign busy_o  = div_q ? (cnt_q != '0) : (shr_q != '0);
  assign prod_o  = acc_q;
  assign quot_o  = shr_q;
  assign rem_sh  = {rem_q, shr_q[MW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    div_d   = div_q;
    shr_d   = shr_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    mcand_d = mcand_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      div_d   = div_i;
      shr_d   = mpl_i;
      cnt_d   = div_i ? DIV_STEPS : '0;
      acc_d   = '0;
      mcand_d = mcand_i;
      rem_d   = '0;
      dvs_d   = divisor_i;
    end else if (busy_o) begin
      if (div_q) begin
        rem_d = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        shr_d = {shr_q[MW-2:0], ge};
        cnt_d = cnt_q - 1'b1;
      end else begin
        if (shr_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d = {mcand_q[AW-2:0], 1'b0};
        shr_d   = {1'b0, shr_q[MW-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= 1'b0;
      shr_q <= '0;
      cnt_q <= '0;
    end else begin
      div_q <= div_d;
      shr_q <= shr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
  end

`include "adaptive_search_stop_unit_assert.svh"

  `ADSS_ASSERT_IMP(a_start_when_idle, start_i, !busy_o, "operation started while unit busy")
  `ADSS_ASSERT_NXT(a_div_count, div_q && busy_o, cnt_q == $past(cnt_q) - 1'b1 || start_i == 1'b0 && $past(start_i), "divide step count slipped")

endmodule

`default_nettype wire

// File: hdl/adss_dp.sv
`default_nettype none

module adss_dp #(
  parameter int unsigned GAIN_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire adss_pkg::dp_cmd_t                cmd_i,
  output adss_pkg::dp_status_t                  status_o,
  input  wire logic [GAIN_WIDTH-1:0]            gain_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [adss_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [adss_pkg::CFG_W-1:0]       cfg_data_i,
  output logic                                  stop_o,
  output logic [adss_pkg::STEPS_W-1:0]          steps_o,
  output logic [adss_pkg::MEAN_W-1:0]           mean_o,
  output logic [adss_pkg::VAR_W-1:0]            var_o
);

  localparam int unsigned SW = adss_pkg::STEPS_W;
  localparam int unsigned MW = adss_pkg::MEAN_W;
  localparam int unsigned OW = adss_pkg::SOS_W;
  localparam int unsigned VW = adss_pkg::VAR_W;
  localparam int unsigned CW = adss_pkg::CFG_W;
  localparam int unsigned AW = adss_pkg::ACC_W;
  localparam int unsigned PW = adss_pkg::MPL_W;
  localparam int unsigned LW = AW + 9;
  localparam logic signed [63:0] MEAN_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] MEAN_MIN = -MEAN_MAX - 64'sd1;
  localparam logic signed [63:0] LIM      = MEAN_MAX >>> FRAC_BITS;
  localparam logic signed [63:0] LIM_LO   = -LIM - 64'sd1;

  logic [CW-1:0] alpha_q, beta_q;
  logic [SW-1:0] steps_q;
  logic [MW-1:0] mean_q;
  logic [OW-1:0] sos_q;
  logic [VW-1:0] var_q;
  logic          stop_q;
  logic [MW-1:0] gq_q;
  logic [MW:0]   dmag_q;
  logic          dneg_q;
  logic [AW-1:0] lhs_q;

  logic signed [63:0] g_ext, gq_full;
  logic [MW-1:0] gq;
  logic [MW:0]   dold, dold_mag, qv, delta, mean_sum;
  logic [MW-1:0] mmag;
  logic [AW-1:0] prod, prod_shr;
  logic [PW-1:0] quot;
  logic [OW-1:0] term, sos_next;
  logic [OW:0]   sos_sum;
  logic [VW-1:0] var_next;
  logic          gt_beta, quick;
  logic [LW-1:0] lhs_ext, rhs_ext;

  logic          md_start, md_div, md_busy;
  logic [AW-1:0] md_mcand;
  logic [PW-1:0] md_mpl;
  logic [SW-1:0] md_dvs;

  assign g_ext = {{(64 - GAIN_WIDTH){gain_i[GAIN_WIDTH-1]}}, gain_i};

  always_comb begin
    if (g_ext > LIM) begin
      gq_full = MEAN_MAX;
    end else if (g_ext < LIM_LO) begin
      gq_full = MEAN_MIN;
    end else begin
      gq_full = g_ext <<< FRAC_BITS;
    end
  end

  assign gq       = gq_full[MW-1:0];
  assign dold     = {gq_q[MW-1], gq_q} - {mean_q[MW-1], mean_q};
  assign dold_mag = dold[MW] ? (~dold + 1'b1) : dold;
  assign qv       = quot[MW:0];
  assign delta    = dneg_q ? (~qv + 1'b1) : qv;
  assign mean_sum = {mean_q[MW-1], mean_q} + delta;
  assign mmag     = mean_q[MW-1] ? (~mean_q + 1'b1) : mean_q;

  assign prod_shr = prod >> FRAC_BITS;
  assign term     = (prod_shr[AW-1:OW] != '0) ? '1 : prod_shr[OW-1:0];
  assign sos_sum  = {1'b0, sos_q} + {1'b0, term};
  assign sos_next = sos_sum[OW] ? '1 : sos_sum[OW-1:0];
  assign var_next = quot[PW-1] ? '1 : quot[VW-1:0];

  assign gt_beta  = {8'b0, steps_q, 8'b0} > {{SW{1'b0}}, beta_q};
  assign quick    = !gt_beta || (mean_q == '0) || (alpha_q <= adss_pkg::ALPHA_HALF);
  assign lhs_ext  = {lhs_q, 9'b0};
  assign rhs_ext  = {{(LW - AW){1'b0}}, prod} << FRAC_BITS;

  assign status_o.first = steps_q == SW'(1);
  assign status_o.quick = quick;
  assign status_o.busy  = md_busy;

  always_comb begin
    md_start = 1'b0;
    md_div   = 1'b0;
    md_mcand = '0;
    md_mpl   = '0;
    md_dvs   = '0;
    case (cmd_i.op)
      adss_pkg::OP_DIV1: begin
        md_start = 1'b1;
        md_div   = 1'b1;
        md_mpl   = {{(PW - MW - 1){1'b0}}, dold_mag};
        md_dvs   = steps_q;
      end
      adss_pkg::OP_MUL1: begin
        md_start = 1'b1;
        md_mcand = {{(AW - MW - 1){1'b0}}, dmag_q};
        md_mpl   = {{(PW - MW - 1){1'b0}}, dold_mag};
      end
      adss_pkg::OP_DIV2: begin
        md_start = 1'b1;
        md_div   = 1'b1;
        md_mpl   = sos_q;
        md_dvs   = steps_q - 1'b1;
      end
      adss_pkg::OP_EVAL: begin
        md_start = !quick;
        md_mcand = {{(AW - MW){1'b0}}, mmag};
        md_mpl   = {{(PW - MW){1'b0}}, mmag};
      end
      adss_pkg::OP_STEP: begin
        md_start = 1'b1;
        md_mcand = prod;
        md_mpl   = {{(PW - SW){1'b0}}, steps_q};
      end
      adss_pkg::OP_AMUL: begin
        md_start = 1'b1;
        md_mcand = {{(AW - VW){1'b0}}, var_q};
        md_mpl   = {{(PW - CW){1'b0}}, alpha_q - adss_pkg::ALPHA_HALF};
      end
      default: begin
      end
    endcase
  end

  adss_muldiv u_muldiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (md_start),
    .div_i     (md_div),
    .mcand_i   (md_mcand),
    .mpl_i     (md_mpl),
    .divisor_i (md_dvs),
    .busy_o    (md_busy),
    .prod_o    (prod),
    .quot_o    (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= adss_pkg::ALPHA_RESET;
      beta_q  <= adss_pkg::BETA_RESET;
      steps_q <= '0;
      mean_q  <= '0;
      sos_q   <= '0;
      var_q   <= '0;
      stop_q  <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == adss_pkg::CFG_ALPHA)) begin
        alpha_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == adss_pkg::CFG_BETA)) begin
        beta_q <= cfg_data_i;
      end
      case (cmd_i.op)
        adss_pkg::OP_LATCH: begin
          if (cmd_i.func) begin
            steps_q <= '0;
            var_q   <= '0;
          end else if (steps_q != '1) begin
            steps_q <= steps_q + 1'b1;
          end
        end
        adss_pkg::OP_FIRST: begin
          mean_q <= gq_q;
          sos_q  <= '0;
        end
        adss_pkg::OP_MEAN: mean_q <= mean_sum[MW-1:0];
        adss_pkg::OP_SACC: sos_q <= sos_next;
        adss_pkg::OP_VAR:  var_q <= var_next;
        adss_pkg::OP_EVAL: stop_q <= gt_beta;
        adss_pkg::OP_CMP:  stop_q <= lhs_ext >= rhs_ext;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      adss_pkg::OP_LATCH: gq_q <= gq;
      adss_pkg::OP_DIV1: begin
        dmag_q <= dold_mag;
        dneg_q <= dold[MW];
      end
      adss_pkg::OP_AMUL: lhs_q <= prod;
      adss_pkg::OP_OUT: begin
        stop_o  <= stop_q;
        steps_o <= steps_q;
        mean_o  <= mean_q;
        var_o   <= var_q;
      end
      default: begin
      end
    endcase
  end

`include "adaptive_search_stop_unit_assert.svh"

  `ADSS_ASSERT_NXT(a_steps_hold, cmd_i.op != adss_pkg::OP_LATCH, $stable(steps_q),
                   "step count moved outside an item load")
  `ADSS_ASSERT_NXT(a_mean_hold,
                   cmd_i.op != adss_pkg::OP_FIRST && cmd_i.op != adss_pkg::OP_MEAN,
                   $stable(mean_q), "mean moved outside a mean update")

endmodule

`default_nettype wire

// File: hdl/adss_ctrl.sv
`default_nettype none

module adss_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_func_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire adss_pkg::dp_status_t  status_i,
  output adss_pkg::dp_cmd_t          cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'h001,
    S_CHK   = 12'h002,
    S_WDIV1 = 12'h004,
    S_MUL1  = 12'h008,
    S_WMUL1 = 12'h010,
    S_DIV2  = 12'h020,
    S_WDIV2 = 12'h040,
    S_EVAL  = 12'h080,
    S_WSQ   = 12'h100,
    S_WSTEP = 12'h200,
    S_WAMUL = 12'h400,
    S_DONE  = 12'h800
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = adss_pkg::OP_NONE;
    cmd_o.func  = in_func_i;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = adss_pkg::OP_LATCH;
          state_d  = in_func_i ? S_EVAL : S_CHK;
        end
      end
      S_CHK: begin
        if (status_i.first) begin
          cmd_o.op = adss_pkg::OP_FIRST;
          state_d  = S_EVAL;
        end else begin
          cmd_o.op = adss_pkg::OP_DIV1;
          state_d  = S_WDIV1;
        end
      end
      S_WDIV1: begin
        if (!status_i.busy) begin
          cmd_o.op = adss_pkg::OP_MEAN;
          state_d  = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd_o.op = adss_pkg::OP_MUL1;
        state_d  = S_WMUL1;
      end
      S_WMUL1: begin
        if (!status_i.busy) begin
          cmd_o.op = adss_pkg::OP_SACC;
          state_d  = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd_o.op = adss_pkg::OP_DIV2;
        state_d  = S_WDIV2;
      end
      S_WDIV2: begin
        if (!status_i.busy) begin
          cmd_o.op = adss_pkg::OP_VAR;
          state_d  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.op = adss_pkg::OP_EVAL;
        state_d  = status_i.quick ? S_DONE : S_WSQ;
      end
      S_WSQ: begin
        if (!status_i.busy) begin
          cmd_o.op = adss_pkg::OP_STEP;
          state_d  = S_WSTEP;
        end
      end
      S_WSTEP: begin
        if (!status_i.busy) begin
          cmd_o.op = adss_pkg::OP_AMUL;
          state_d  = S_WAMUL;
        end
      end
      S_WAMUL: begin
        if (!status_i.busy) begin
          cmd_o.op = adss_pkg::OP_CMP;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = adss_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`include "adaptive_search_stop_unit_assert.svh"

  `ADSS_ASSERT_NXT(a_accept_leaves_idle, in_valid_i && in_ready_o, state_q != S_IDLE,
                   "accepted item did not start work")
  `ADSS_ASSERT_NXT(a_done_waits, state_q == S_DONE && out_valid_q && !out_ready_i,
                   state_q == S_DONE && out_valid_q, "result overwrote a waiting result")

endmodule

`default_nettype wire

// File: hdl/adaptive_search_stop_unit.sv
// Adaptive stopping rule for a local move search.
// Input channel in_i carries func (0 = update with a signed gain, 1 = clear the
// step count and variance) and gain. Output channel out_o carries one result per
// item: stop, steps, mean_q16 and variance_q16, with FRAC_BITS fraction bits.
// Both channels move an item when valid and ready are high at a clock edge.
// Items are worked on one at a time by a shift-add multiplier and a restoring
// divider that share one unit. A reset item and the first gain after a reset
// skip the mean and variance updates; any other gain runs a divide for the mean,
// a multiply for the square term and a divide for the variance. Unless the stop
// test is settled early, it then runs three multiplies for the full test; a reset
// item always settles it early.
// The result register lets the next item be accepted while a result waits;
// that next item then holds in its last state until the receiver takes it.
// Configuration writes are registered. The user must make them only while the
// block is idle; the block itself does not enforce this.
// After reset alpha is 1.0, beta is 0 and all statistics are zero.
`default_nettype none

module adaptive_search_stop_unit #(
  parameter int unsigned GAIN_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  adss_in_if.sink                              in_i,
  adss_out_if.source                           out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [adss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [adss_pkg::CFG_W-1:0]      cfg_data_i
);

  adss_pkg::dp_cmd_t    cmd;
  adss_pkg::dp_status_t status;
  logic                 in_ready;
  logic                 out_valid;
  logic [adss_pkg::MEAN_W-1:0] mean;

  assign in_i.ready     = in_ready;
  assign out_o.valid    = out_valid;
  assign out_o.mean_q16 = $signed(mean);

  adss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_func_i   (in_i.func),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  adss_dp #(
    .GAIN_WIDTH (GAIN_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .gain_i     (in_i.gain[GAIN_WIDTH-1:0]),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .stop_o     (out_o.stop),
    .steps_o    (out_o.steps),
    .mean_o     (mean),
    .var_o      (out_o.variance_q16)
  );

endmodule

`default_nettype wire
